// File: hdl/oait_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oait_pkg: shared definitions of the open address identifier table
// Default sizes, field widths, command, status and slot mark codes.
// ----------------------------------------------------------------------------
package oait_pkg;

    localparam int SLOT_BITS_DEF   = 10;
    localparam int KEY_BITS_DEF    = 31;
    localparam int HANDLE_BITS_DEF = 16;

    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 3;
    localparam int MARK_BITS   = 2;
    localparam int MASK_RESET  = 15;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LOOKUP = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_IN_USE    = 3'd2,
        ST_FULL      = 3'd3,
        ST_ZERO_KEY  = 3'd4
    } t_status;

    typedef enum logic [MARK_BITS-1:0] {
        MARK_EMPTY = 2'd0,
        MARK_LIVE  = 2'd1,
        MARK_TOMB  = 2'd2
    } t_mark;

endpackage

// File: hdl/open_address_id_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_address_id_table: identifier table with perturbed open addressing
// Inserts, deletes and looks up key/handle pairs in a tombstoned hash table.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot marks to empty, one slot per cycle,
// and accepts no command until the sweep is done; the mask register can be
// written meanwhile. Each probed slot is read through the single registered
// read port of the slot memories (S_ADDR, then S_CHECK); a rejected insert
// and an unknown command skip the probe and go straight to S_DONE. One
// command is worked on at a time, and the next one is accepted while the
// previous result still waits in the output register.
module open_address_id_table #(
    parameter int SLOT_BITS   = oait_pkg::SLOT_BITS_DEF,
    parameter int KEY_BITS    = oait_pkg::KEY_BITS_DEF,
    parameter int HANDLE_BITS = oait_pkg::HANDLE_BITS_DEF,
    localparam int IN_W  = ((oait_pkg::CMD_BITS + KEY_BITS + HANDLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((oait_pkg::STATUS_BITS + HANDLE_BITS + SLOT_BITS + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [SLOT_BITS-1:0] i_cfg_wr_data,  // table_mask
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,   // cmd, key, handle
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata    // status, handle_out, slot_out
);
    import oait_pkg::*;

    localparam int KEY_LO = CMD_BITS;
    localparam int HDL_LO = CMD_BITS + KEY_BITS;

    logic [SLOT_BITS-1:0]   r_mask;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_data;

    logic                   in_acc;
    logic                   ready;
    logic                   res_valid;
    logic                   res_taken;
    logic [STATUS_BITS-1:0] res_status;
    logic [HANDLE_BITS-1:0] res_handle;
    logic [SLOT_BITS-1:0]   res_slot;

    logic                   rd_en;
    logic [SLOT_BITS-1:0]   rd_addr;
    logic [MARK_BITS-1:0]   rd_mark;
    logic [KEY_BITS-1:0]    rd_key;
    logic [HANDLE_BITS-1:0] rd_owner;
    logic [SLOT_BITS-1:0]   wr_addr;
    logic                   mark_we;
    logic [MARK_BITS-1:0]   mark_wdata;
    logic                   entry_we;
    logic [KEY_BITS-1:0]    key_wdata;
    logic [HANDLE_BITS-1:0] owner_wdata;

    assign in_acc        = s_axis_tvalid && ready;
    assign s_axis_tready = ready;
    assign res_taken     = res_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= SLOT_BITS'(MASK_RESET);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mask <= i_cfg_wr_data;
            end
            if (res_taken) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_taken) begin
            r_out_data <= OUT_W'({res_slot, res_handle, res_status});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    oait_ctrl #(
        .SLOT_BITS   (SLOT_BITS),
        .KEY_BITS    (KEY_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mask        (r_mask),
        .o_ready       (ready),
        .i_in_acc      (in_acc),
        .i_cmd         (s_axis_tdata[CMD_BITS-1:0]),
        .i_key         (s_axis_tdata[HDL_LO-1:KEY_LO]),
        .i_handle      (s_axis_tdata[HDL_LO+HANDLE_BITS-1:HDL_LO]),
        .o_res_valid   (res_valid),
        .i_res_taken   (res_taken),
        .o_status      (res_status),
        .o_handle_out  (res_handle),
        .o_slot_out    (res_slot),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_mark     (rd_mark),
        .i_rd_key      (rd_key),
        .i_rd_owner    (rd_owner),
        .o_wr_addr     (wr_addr),
        .o_mark_we     (mark_we),
        .o_mark_wdata  (mark_wdata),
        .o_entry_we    (entry_we),
        .o_key_wdata   (key_wdata),
        .o_owner_wdata (owner_wdata)
    );

    oait_store #(
        .SLOT_BITS   (SLOT_BITS),
        .KEY_BITS    (KEY_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_store (
        .i_clk         (i_clk),
        .i_rd_en       (rd_en),
        .i_rd_addr     (rd_addr),
        .o_rd_mark     (rd_mark),
        .o_rd_key      (rd_key),
        .o_rd_owner    (rd_owner),
        .i_wr_addr     (wr_addr),
        .i_mark_we     (mark_we),
        .i_mark_wdata  (mark_wdata),
        .i_entry_we    (entry_we),
        .i_key_wdata   (key_wdata),
        .i_owner_wdata (owner_wdata)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input accepted while a command is in progress");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !s_axis_tready)
        else $error("input ready before the mark clearing pass");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[STATUS_BITS-1:0] <= STATUS_BITS'(ST_ZERO_KEY)))
        else $error("result status out of range");

    a_write_on_handover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        entry_we |-> (res_taken && mark_we))
        else $error("entry written without a mark write at result handover");

endmodule

// File: hdl/oait_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oait_store: slot memories of the identifier table
// A mark memory and a key/owner memory, one write and one registered read
// port each, sharing addresses.
// ----------------------------------------------------------------------------
module oait_store #(
    parameter int SLOT_BITS   = oait_pkg::SLOT_BITS_DEF,
    parameter int KEY_BITS    = oait_pkg::KEY_BITS_DEF,
    parameter int HANDLE_BITS = oait_pkg::HANDLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [SLOT_BITS-1:0]          i_rd_addr,
    output logic [oait_pkg::MARK_BITS-1:0] o_rd_mark,
    output logic [KEY_BITS-1:0]           o_rd_key,
    output logic [HANDLE_BITS-1:0]        o_rd_owner,
    input  logic [SLOT_BITS-1:0]          i_wr_addr,
    input  logic                          i_mark_we,
    input  logic [oait_pkg::MARK_BITS-1:0] i_mark_wdata,
    input  logic                          i_entry_we,
    input  logic [KEY_BITS-1:0]           i_key_wdata,
    input  logic [HANDLE_BITS-1:0]        i_owner_wdata
);
    import oait_pkg::*;

    localparam int SLOT_COUNT = 1 << SLOT_BITS;
    localparam int ENTRY_BITS = KEY_BITS + HANDLE_BITS;

    logic [MARK_BITS-1:0]  r_mark_mem  [SLOT_COUNT];
    logic [ENTRY_BITS-1:0] r_entry_mem [SLOT_COUNT];
    logic [MARK_BITS-1:0]  r_rd_mark;
    logic [ENTRY_BITS-1:0] r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_mark_we) begin
            r_mark_mem[i_wr_addr] <= i_mark_wdata;
        end
        if (i_rd_en) begin
            r_rd_mark <= r_mark_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_entry_we) begin
            r_entry_mem[i_wr_addr] <= {i_owner_wdata, i_key_wdata};
        end
        if (i_rd_en) begin
            r_rd_entry <= r_entry_mem[i_rd_addr];
        end
    end

    assign o_rd_mark  = r_rd_mark;
    assign o_rd_key   = r_rd_entry[KEY_BITS-1:0];
    assign o_rd_owner = r_rd_entry[ENTRY_BITS-1:KEY_BITS];

endmodule

// File: hdl/oait_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oait_ctrl: probe sequencer of the identifier table
// Clears the marks after reset, walks the perturbed probe sequence one slot
// read at a time and writes the slot back when the result is handed over.
// ----------------------------------------------------------------------------
module oait_ctrl #(
    parameter int SLOT_BITS   = oait_pkg::SLOT_BITS_DEF,
    parameter int KEY_BITS    = oait_pkg::KEY_BITS_DEF,
    parameter int HANDLE_BITS = oait_pkg::HANDLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [SLOT_BITS-1:0]            i_mask,
    output logic                            o_ready,
    input  logic                            i_in_acc,
    input  logic [oait_pkg::CMD_BITS-1:0]   i_cmd,
    input  logic [KEY_BITS-1:0]             i_key,
    input  logic [HANDLE_BITS-1:0]          i_handle,
    output logic                            o_res_valid,
    input  logic                            i_res_taken,
    output logic [oait_pkg::STATUS_BITS-1:0] o_status,
    output logic [HANDLE_BITS-1:0]          o_handle_out,
    output logic [SLOT_BITS-1:0]            o_slot_out,
    output logic                            o_rd_en,
    output logic [SLOT_BITS-1:0]            o_rd_addr,
    input  logic [oait_pkg::MARK_BITS-1:0]  i_rd_mark,
    input  logic [KEY_BITS-1:0]             i_rd_key,
    input  logic [HANDLE_BITS-1:0]          i_rd_owner,
    output logic [SLOT_BITS-1:0]            o_wr_addr,
    output logic                            o_mark_we,
    output logic [oait_pkg::MARK_BITS-1:0]  o_mark_wdata,
    output logic                            o_entry_we,
    output logic [KEY_BITS-1:0]             o_key_wdata,
    output logic [HANDLE_BITS-1:0]          o_owner_wdata
);
    import oait_pkg::*;

    localparam int CNT_BITS = SLOT_BITS + 1;
    localparam logic [CNT_BITS-1:0] PROBE_LAST = CNT_BITS'((1 << SLOT_BITS) + 3);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_ADDR  = 5'b00100,
        S_CHECK = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [SLOT_BITS-1:0]   r_clr, n_clr;
    logic [CMD_BITS-1:0]    r_cmd, n_cmd;
    logic [KEY_BITS-1:0]    r_key, n_key;
    logic [HANDLE_BITS-1:0] r_handle, n_handle;
    logic [SLOT_BITS-1:0]   r_idx, n_idx;
    logic [SLOT_BITS-1:0]   r_perturb, n_perturb;
    logic [CNT_BITS-1:0]    r_cnt, n_cnt;
    logic                   r_have_free, n_have_free;
    logic                   r_free_empty, n_free_empty;
    logic [SLOT_BITS-1:0]   r_free_slot, n_free_slot;
    t_status                r_status, n_status;
    logic [HANDLE_BITS-1:0] r_handle_out, n_handle_out;
    logic [SLOT_BITS-1:0]   r_slot_out, n_slot_out;
    logic [CNT_BITS-1:0]    r_live, n_live;
    logic [CNT_BITS-1:0]    r_filled, n_filled;

    logic [SLOT_BITS-1:0]   cur_slot;
    logic [KEY_BITS+SLOT_BITS-1:0] key_ext;
    logic [SLOT_BITS-1:0]   key_slot;
    logic [SLOT_BITS+2:0]   step_sum;
    logic                   wb_go;
    logic                   is_insert;

    assign cur_slot  = r_idx & i_mask;
    assign key_ext   = {{SLOT_BITS{1'b0}}, i_key};
    assign key_slot  = key_ext[SLOT_BITS-1:0] & i_mask;
    assign step_sum  = {1'b0, r_idx, 2'b00} + {3'b000, r_idx} + {3'b000, r_perturb}
                     + (SLOT_BITS+3)'(1);
    assign is_insert = (r_cmd == CMD_INSERT);
    assign wb_go     = (r_state == S_DONE) && i_res_taken && (r_status == ST_OK);

    always_comb begin
        logic hf;
        logic fe;
        logic [SLOT_BITS-1:0] fs;
        logic hit;
        logic stop;
        n_state      = r_state;
        n_clr        = r_clr;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_handle     = r_handle;
        n_idx        = r_idx;
        n_perturb    = r_perturb;
        n_cnt        = r_cnt;
        n_have_free  = r_have_free;
        n_free_empty = r_free_empty;
        n_free_slot  = r_free_slot;
        n_status     = r_status;
        n_handle_out = r_handle_out;
        n_slot_out   = r_slot_out;
        n_live       = r_live;
        n_filled     = r_filled;
        hf           = r_have_free;
        fe           = r_free_empty;
        fs           = r_free_slot;
        hit          = 1'b0;
        stop         = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_acc) begin
                    n_cmd        = i_cmd;
                    n_key        = i_key;
                    n_handle     = i_handle;
                    n_idx        = key_slot;
                    n_perturb    = key_slot;
                    n_cnt        = '0;
                    n_have_free  = 1'b0;
                    n_free_empty = 1'b0;
                    n_free_slot  = '0;
                    n_handle_out = '0;
                    n_slot_out   = '0;
                    priority if (i_cmd != CMD_INSERT && i_cmd != CMD_DELETE
                                 && i_cmd != CMD_LOOKUP) begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end else if (i_cmd == CMD_INSERT && i_key == '0) begin
                        n_status = ST_ZERO_KEY;
                        n_state  = S_DONE;
                    end else if (i_cmd == CMD_INSERT
                                 && r_filled >= {1'b0, i_mask >> 1}) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_ADDR;
                    end
                end
            end
            S_ADDR: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_rd_mark == MARK_EMPTY) begin
                    if (!hf) begin
                        hf = 1'b1;
                        fe = 1'b1;
                        fs = cur_slot;
                    end
                    stop = 1'b1;
                end else if (i_rd_mark == MARK_LIVE) begin
                    if (is_insert && i_rd_key == r_key) begin
                        hit      = 1'b1;
                        n_status = ST_IN_USE;
                    end else if (r_cmd == CMD_DELETE && i_rd_owner == r_handle) begin
                        hit        = 1'b1;
                        n_status   = ST_OK;
                        n_slot_out = cur_slot;
                    end else if (r_cmd == CMD_LOOKUP && i_rd_key == r_key) begin
                        hit          = 1'b1;
                        n_status     = ST_OK;
                        n_handle_out = i_rd_owner;
                        n_slot_out   = cur_slot;
                    end
                end else if (!hf) begin
                    hf = 1'b1;
                    fs = cur_slot;
                end
                n_have_free  = hf;
                n_free_empty = fe;
                n_free_slot  = fs;
                if (hit) begin
                    n_state = S_DONE;
                end else if (stop || r_cnt == PROBE_LAST) begin
                    n_state = S_DONE;
                    priority if (!is_insert) begin
                        n_status = ST_NOT_FOUND;
                    end else if (!hf) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status   = ST_OK;
                        n_slot_out = fs;
                    end
                end else begin
                    n_idx     = step_sum[SLOT_BITS-1:0];
                    n_perturb = r_perturb >> 5;
                    n_cnt     = r_cnt + 1'b1;
                    n_state   = S_ADDR;
                end
            end
            S_DONE: begin
                if (i_res_taken) begin
                    n_state = S_IDLE;
                    if (wb_go && is_insert) begin
                        n_live = r_live + 1'b1;
                        if (r_free_empty) begin
                            n_filled = r_filled + 1'b1;
                        end
                    end else if (wb_go && r_cmd == CMD_DELETE && r_live != '0) begin
                        n_live = r_live - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_live   <= '0;
            r_filled <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_live   <= n_live;
            r_filled <= n_filled;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_handle     <= n_handle;
        r_idx        <= n_idx;
        r_perturb    <= n_perturb;
        r_cnt        <= n_cnt;
        r_have_free  <= n_have_free;
        r_free_empty <= n_free_empty;
        r_free_slot  <= n_free_slot;
        r_status     <= n_status;
        r_handle_out <= n_handle_out;
        r_slot_out   <= n_slot_out;
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_status     = r_status;
    assign o_handle_out = r_handle_out;
    assign o_slot_out   = r_slot_out;

    assign o_rd_en   = (r_state == S_ADDR);
    assign o_rd_addr = cur_slot;

    assign o_wr_addr     = (r_state == S_CLEAR) ? r_clr : r_slot_out;
    assign o_mark_we     = (r_state == S_CLEAR)
                         || (wb_go && (is_insert || r_cmd == CMD_DELETE));
    assign o_mark_wdata  = (r_state == S_CLEAR) ? MARK_EMPTY
                         : (is_insert ? MARK_LIVE : MARK_TOMB);
    assign o_entry_we    = wb_go && is_insert;
    assign o_key_wdata   = r_key;
    assign o_owner_wdata = r_handle;

endmodule
